// ----- rtl/core/wsfd_pkg.sv -----
package wsfd_pkg;

	// Header parsing steps, one-hot.
	typedef enum logic [5:0] {
		ST_FIRST   = 6'b000001,
		ST_LEN     = 6'b000010,
		ST_EXT16   = 6'b000100,
		ST_EXT64   = 6'b001000,
		ST_MASK    = 6'b010000,
		ST_PAYLOAD = 6'b100000
	} step_t;

	// Result kinds.
	localparam logic [2:0] KIND_DATA    = 3'd0;
	localparam logic [2:0] KIND_EMPTY   = 3'd1;
	localparam logic [2:0] KIND_STRAY   = 3'd2;
	localparam logic [2:0] KIND_BAD_LEN = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;
	localparam logic [2:0] KIND_ABANDON = 3'd5;

	// Message types.
	localparam logic [1:0] MSG_TEXT   = 2'd0;
	localparam logic [1:0] MSG_BINARY = 2'd1;
	localparam logic [1:0] MSG_CLOSE  = 2'd2;
	localparam logic [1:0] MSG_PING   = 2'd3;

	// Frame opcodes.
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// Seven-bit length codes that announce an extended length.
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// Header byte counts, as the value of the counter on the last byte.
	localparam logic [2:0] CNT_EXT16_LAST = 3'd1;
	localparam logic [2:0] CNT_EXT64_LAST = 3'd7;
	localparam logic [2:0] CNT_MASK_LAST  = 3'd3;

	// One result item.
	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] msg_type;
		logic [7:0] data_byte;
		logic       last;
	} result_t;

endpackage

// ----- rtl/core/wsfd_parser.sv -----
module wsfd_parser
	import wsfd_pkg::*;
#(
	parameter int LEN_BITS = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	step_t               step_q, step_d;
	logic                fin_q, fin_d;
	logic [3:0]          op_q, op_d;
	logic                masked_q, masked_d;
	logic [LEN_BITS-1:0] remain_q, remain_d;
	logic [31:0]         key_q, key_d;
	logic [1:0]          midx_q, midx_d;
	logic                frag_valid_q, frag_valid_d;
	logic [1:0]          frag_type_q, frag_type_d;
	logic [2:0]          cnt_q, cnt_d;
	logic [LEN_BITS-1:0] acc_q, acc_d;
	logic                high_q, high_d;

	logic [LEN_BITS-1:0] len_val;
	logic                do_len;
	logic                do_finish;
	logic                empty;
	logic                done;
	logic                high_n;
	logic [7:0]          key_byte;
	logic [7:0]          plain_byte;
	logic [15:0]         acc16;

	// Key byte for the current payload position; the first key byte sits on top.
	always_comb begin
		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign plain_byte = masked_q ? (rx_byte ^ key_byte) : rx_byte;
	assign acc16      = {acc_q[7:0], rx_byte};
	assign high_n     = high_q | (|acc_q[LEN_BITS-1 -: 8]);

	// Next state and result for the byte at the input.
	always_comb begin
		step_d       = step_q;
		fin_d        = fin_q;
		op_d         = op_q;
		masked_d     = masked_q;
		remain_d     = remain_q;
		key_d        = key_q;
		midx_d       = midx_q;
		frag_valid_d = frag_valid_q;
		frag_type_d  = frag_type_q;
		cnt_d        = cnt_q;
		acc_d        = acc_q;
		high_d       = high_q;
		res_valid    = 1'b0;
		res          = '0;
		len_val      = '0;
		do_len       = 1'b0;
		do_finish    = 1'b0;
		done         = 1'b0;

		case (step_q)
			ST_FIRST: begin
				fin_d  = rx_byte[7];
				op_d   = rx_byte[3:0];
				step_d = ST_LEN;
			end
			ST_LEN: begin
				masked_d = rx_byte[7];
				cnt_d    = '0;
				acc_d    = '0;
				high_d   = 1'b0;
				if (rx_byte[6:0] == LEN7_EXT16) begin
					step_d = ST_EXT16;
				end else if (rx_byte[6:0] == LEN7_EXT64) begin
					step_d = ST_EXT64;
				end else begin
					len_val = LEN_BITS'(rx_byte[6:0]);
					do_len  = 1'b1;
				end
			end
			ST_EXT16: begin
				acc_d = LEN_BITS'(acc16);
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == CNT_EXT16_LAST) begin
					len_val = LEN_BITS'(acc16);
					do_len  = 1'b1;
				end
			end
			ST_EXT64: begin
				acc_d  = {acc_q[LEN_BITS-9:0], rx_byte};
				high_d = high_n;
				cnt_d  = cnt_q + 3'd1;
				if (cnt_q == CNT_EXT64_LAST) begin
					if (high_n) begin
						step_d    = ST_FIRST;
						res_valid = 1'b1;
						res.kind  = KIND_BAD_LEN;
					end else begin
						len_val = {acc_q[LEN_BITS-9:0], rx_byte};
						do_len  = 1'b1;
					end
				end
			end
			ST_MASK: begin
				key_d = {key_q[23:0], rx_byte};
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == CNT_MASK_LAST) begin
					len_val   = remain_q;
					do_finish = 1'b1;
				end
			end
			ST_PAYLOAD: begin
				midx_d = midx_q + 2'd1;
				if (remain_q != '0) begin
					remain_d = remain_q - LEN_BITS'(1);
				end
				done = (remain_d == '0);
				if (done) begin
					step_d = ST_FIRST;
				end
				res.data_byte = plain_byte;
				res.kind      = KIND_DATA;
				if (op_q == OP_CONT) begin
					if (frag_valid_q) begin
						res_valid    = 1'b1;
						res.msg_type = frag_type_q;
						res.last     = done & fin_q;
						if (done && fin_q) begin
							frag_valid_d = 1'b0;
							frag_type_d  = MSG_TEXT;
						end
					end
				end else if (op_q == OP_TEXT || op_q == OP_BINARY) begin
					res_valid    = 1'b1;
					res.msg_type = (op_q == OP_TEXT) ? MSG_TEXT : MSG_BINARY;
					res.last     = done & fin_q;
				end else if (op_q == OP_CLOSE || op_q == OP_PING) begin
					res_valid    = 1'b1;
					res.msg_type = (op_q == OP_CLOSE) ? MSG_CLOSE : MSG_PING;
					res.last     = done;
				end
				if (!res_valid) begin
					res.data_byte = '0;
				end
			end
			default: begin
				step_d = ST_FIRST;
			end
		endcase

		// The length is known: collect the mask key or finish the header.
		if (do_len) begin
			remain_d = len_val;
			if (masked_d) begin
				step_d = ST_MASK;
				cnt_d  = '0;
				key_d  = '0;
			end else begin
				do_finish = 1'b1;
			end
		end

		// Header complete: decide on the frame and the open fragment.
		empty = (len_val == '0);
		if (do_finish) begin
			if (op_q == OP_CONT) begin
				if (!frag_valid_q) begin
					res_valid = 1'b1;
					res.kind  = KIND_STRAY;
				end else if (empty && fin_q) begin
					res_valid    = 1'b1;
					res.kind     = KIND_EMPTY;
					res.msg_type = frag_type_q;
					res.last     = 1'b1;
					frag_valid_d = 1'b0;
					frag_type_d  = MSG_TEXT;
				end
			end else if (op_q == OP_TEXT || op_q == OP_BINARY) begin
				if (!fin_q) begin
					if (frag_valid_q) begin
						res_valid    = 1'b1;
						res.kind     = KIND_ABANDON;
						res.msg_type = frag_type_q;
					end
					frag_valid_d = 1'b1;
					frag_type_d  = (op_q == OP_TEXT) ? MSG_TEXT : MSG_BINARY;
				end else if (empty) begin
					res_valid    = 1'b1;
					res.kind     = KIND_EMPTY;
					res.msg_type = (op_q == OP_TEXT) ? MSG_TEXT : MSG_BINARY;
					res.last     = 1'b1;
				end
			end else if (op_q == OP_CLOSE || op_q == OP_PING) begin
				if (empty) begin
					res_valid    = 1'b1;
					res.kind     = KIND_EMPTY;
					res.msg_type = (op_q == OP_CLOSE) ? MSG_CLOSE : MSG_PING;
					res.last     = 1'b1;
				end
			end else if (op_q != OP_PONG) begin
				res_valid = 1'b1;
				res.kind  = KIND_UNKNOWN;
			end
			midx_d = '0;
			step_d = empty ? ST_FIRST : ST_PAYLOAD;
		end
	end

	// Decoder state, updated on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_FIRST;
			fin_q        <= 1'b0;
			op_q         <= OP_CONT;
			masked_q     <= 1'b0;
			remain_q     <= '0;
			key_q        <= '0;
			midx_q       <= '0;
			frag_valid_q <= 1'b0;
			frag_type_q  <= MSG_TEXT;
			cnt_q        <= '0;
			acc_q        <= '0;
			high_q       <= 1'b0;
		end else if (in_fire) begin
			step_q       <= step_d;
			fin_q        <= fin_d;
			op_q         <= op_d;
			masked_q     <= masked_d;
			remain_q     <= remain_d;
			key_q        <= key_d;
			midx_q       <= midx_d;
			frag_valid_q <= frag_valid_d;
			frag_type_q  <= frag_type_d;
			cnt_q        <= cnt_d;
			acc_q        <= acc_d;
			high_q       <= high_d;
		end
	end

endmodule

// ----- rtl/core/websocket_frame_decoder.sv -----
// Streaming frame decoder, one received byte per accepted item.
// A result item is computed combinationally from the accepted byte and registered in the output stage.
// Throughput: one byte per cycle while in_ready is high; the parser state updates in a single pass.
// A two-entry output stage holds result items while out_ready is low; input
// stalls only while both entries hold an item.
// Reset clears the parser state and empties the output stage; no clearing pass.
module websocket_frame_decoder
	import wsfd_pkg::*;
#(
	parameter int LEN_BITS = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [1:0] msg_type,
	output logic [7:0] data_byte,
	output logic       last
);

	logic    in_fire;
	logic    out_fire;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid_q & out_ready;

	wsfd_parser #(
		.LEN_BITS(LEN_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the output stage.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign msg_type  = out_q.msg_type;
	assign data_byte = out_q.data_byte;
	assign last      = out_q.last;

endmodule
